// ----- design/nsr_pkg.sv -----
// Shared types, constants and helper functions for the nine-slice rectangle generator.
package nsr_pkg;

   // Coordinate format: signed, 8 fraction bits. Widths below follow from it.
   localparam int COORD_BITS = 24;
   localparam int QB         = COORD_BITS - 1;  // sizes, fitted margins, quotients
   localparam int EB         = COORD_BITS + 2;  // unsaturated destination edges

   localparam int LANE_STAGES = QB + 2;         // clamp, multiply, one stage per quotient bit

   localparam int CELL_COUNT  = 9;
   localparam int CENTER_CELL = 4;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam int CSR_COUNT     = 7;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = $clog2(4 * CSR_COUNT);
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TEX_WIDTH     = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEX_HEIGHT    = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_LEFT   = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_TOP    = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_RIGHT  = CSR_IDX_BITS'(4);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_BOTTOM = CSR_IDX_BITS'(5);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_ENABLE = CSR_IDX_BITS'(6);

   typedef enum logic {
      KIND_RECT,
      KIND_SRC_FIT
   } item_kind_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] rect_x;
      logic signed [COORD_BITS-1:0] rect_y;
      logic signed [COORD_BITS-1:0] rect_width;
      logic signed [COORD_BITS-1:0] rect_height;
      logic signed [COORD_BITS-1:0] target_left;
      logic signed [COORD_BITS-1:0] target_top;
      logic signed [COORD_BITS-1:0] target_right;
      logic signed [COORD_BITS-1:0] target_bottom;
   } req_type;

   typedef struct packed {
      logic [3:0]                   cell_index;
      logic [QB-1:0]                piece_src_x;
      logic [QB-1:0]                piece_src_y;
      logic [QB-1:0]                piece_src_width;
      logic [QB-1:0]                piece_src_height;
      logic signed [COORD_BITS-1:0] piece_dst_x;
      logic signed [COORD_BITS-1:0] piece_dst_y;
      logic [QB-1:0]                piece_dst_width;
      logic [QB-1:0]                piece_dst_height;
      logic                         last_piece;
   } rsp_type;

   typedef struct packed {
      logic [QB-1:0]                tex_width;
      logic [QB-1:0]                tex_height;
      logic signed [COORD_BITS-1:0] source_left;
      logic signed [COORD_BITS-1:0] source_top;
      logic signed [COORD_BITS-1:0] source_right;
      logic signed [COORD_BITS-1:0] source_bottom;
      logic                         center_enable;
   } cfg_type;

   // Fitted texture grid: column edges sx[0..3], row edges sy[0..3].
   typedef struct packed {
      logic [3:0][QB-1:0] sx;
      logic [3:0][QB-1:0] sy;
   } src_geom_type;

   // One rectangle as handed from front to back.
   typedef struct packed {
      logic [3:0][EB-1:0]      dx;
      logic [3:0][EB-1:0]      dy;
      logic [CELL_COUNT-1:0]   mask;
   } queue_entry_type;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [EB-1:0] v);
      logic signed [COORD_BITS-1:0] r;
      if (v[EB-1:COORD_BITS-1] == '0 || v[EB-1:COORD_BITS-1] == '1) begin
         r = v[COORD_BITS-1:0];
      end else if (v[EB-1]) begin
         r = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [1:0] cell_row(input logic [3:0] idx);
      logic [1:0] r;
      case (idx)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cell_col(input logic [3:0] idx);
      logic [1:0] c;
      case (idx)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

endpackage

// ----- design/nine_slice_rect_generator.sv -----
// Top level of the nine-slice rectangle generator: registers, front, queue and back.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (rectangle and target margins)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (one source/destination cell pair)
//   csr      in/out     APB csr_psel..pready   tex size, source margins, center enable
//
// Flow: a request produces one response per drawn cell, one per cycle while rsp
// is not stalled, with no gap between rectangles; the output register is the limit.
// rsp_valid for the first cell rises once the request has passed a 25-stage fitting
// pipe (clamp, multiply, one quotient bit per stage, first stage loaded at the
// accepting edge), the edge stage, the queue, the cell walker and the output register.
// Reset: synchronous; clears the pipe, queue, fitted texture grid (zero size) and
// sets the center enable. After any register write the front re-fits the source
// margins through the same pipe and holds req_stall until the re-fit is captured.
// Stalls: the 4-entry queue lets the front keep accepting requests while rsp is
// stalled; when it is full and a rectangle waits, the pipe freezes and req_stall rises.
// Requests that draw no cell are dropped at the edge stage and never reach the queue.
module nine_slice_rect_generator import nsr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,

   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type         cfg;
   logic            cfg_wr;
   src_geom_type    geom;
   logic            q_push, q_pop, q_full, q_empty;
   queue_entry_type q_wdata, q_rdata;

   nsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   // margins fitted and cells classified here
   nsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_wdata   (q_wdata),
      .q_full    (q_full),
      .geom      (geom)
   );

   nsr_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   // one cell per cycle out of the queued rectangle while rsp is not stalled
   nsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .geom      (geom),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/nsr_csr.sv -----
// APB register file: texture size, source margins and center enable.
module nsr_csr import nsr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg,
   output logic                     cfg_wr
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [CSR_IDX_BITS-1:0] idx;

   assign idx        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (idx)
            CSR_TEX_WIDTH:     cfg_in.tex_width     = csr_pwdata[QB-1:0];
            CSR_TEX_HEIGHT:    cfg_in.tex_height    = csr_pwdata[QB-1:0];
            CSR_SOURCE_LEFT:   cfg_in.source_left   = csr_pwdata[COORD_BITS-1:0];
            CSR_SOURCE_TOP:    cfg_in.source_top    = csr_pwdata[COORD_BITS-1:0];
            CSR_SOURCE_RIGHT:  cfg_in.source_right  = csr_pwdata[COORD_BITS-1:0];
            CSR_SOURCE_BOTTOM: cfg_in.source_bottom = csr_pwdata[COORD_BITS-1:0];
            CSR_CENTER_ENABLE: cfg_in.center_enable = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_TEX_WIDTH:     csr_prdata = CSR_DATA_BITS'(cfg_ff.tex_width);
         CSR_TEX_HEIGHT:    csr_prdata = CSR_DATA_BITS'(cfg_ff.tex_height);
         CSR_SOURCE_LEFT:   csr_prdata = CSR_DATA_BITS'($unsigned(cfg_ff.source_left));
         CSR_SOURCE_TOP:    csr_prdata = CSR_DATA_BITS'($unsigned(cfg_ff.source_top));
         CSR_SOURCE_RIGHT:  csr_prdata = CSR_DATA_BITS'($unsigned(cfg_ff.source_right));
         CSR_SOURCE_BOTTOM: csr_prdata = CSR_DATA_BITS'($unsigned(cfg_ff.source_bottom));
         CSR_CENTER_ENABLE: csr_prdata = CSR_DATA_BITS'(cfg_ff.center_enable);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tex_width: '0, tex_height: '0, source_left: '0, source_top: '0,
                     source_right: '0, source_bottom: '0, center_enable: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/nsr_fit_lane.sv -----
// Fitting pipe for one margin pair: clamp, then on overrun a*size/sum, divided bit per stage.
module nsr_fit_lane import nsr_pkg::*; (
   input  logic                         clock,
   input  logic                         adv,
   input  logic signed [COORD_BITS-1:0] a_in,
   input  logic signed [COORD_BITS-1:0] b_in,
   input  logic signed [COORD_BITS-1:0] size_in,
   output logic [QB-1:0]                qa_out,
   output logic [QB-1:0]                qb_out
);

   // stage 1: clamped operands
   logic [QB-1:0] a_c, b_c, s_c;
   logic [QB:0]   sum_c;
   logic [QB-1:0] a1_ff, b1_ff, s1_ff;
   logic [QB:0]   sum1_ff;
   logic          fit1_ff;

   // stage 2: products and divider seed
   logic [2*QB-1:0] pa, pb, dvd_a, dvd_b;
   logic [QB:0]     dvs;

   // divider stages 0..QB, stage 0 is the seed
   logic [QB:0]   rem_a_ff [QB+1];
   logic [QB:0]   rem_b_ff [QB+1];
   logic [QB-1:0] sh_a_ff  [QB+1];
   logic [QB-1:0] sh_b_ff  [QB+1];
   logic [QB:0]   d_ff     [QB+1];

   logic [QB+1:0] t_a [QB];
   logic [QB+1:0] t_b [QB];
   logic [QB+1:0] df_a [QB];
   logic [QB+1:0] df_b [QB];
   logic          ge_a [QB];
   logic          ge_b [QB];

   always_comb begin
      a_c   = a_in[COORD_BITS-1]    ? '0 : a_in[QB-1:0];
      b_c   = b_in[COORD_BITS-1]    ? '0 : b_in[QB-1:0];
      s_c   = size_in[COORD_BITS-1] ? '0 : size_in[QB-1:0];
      sum_c = {1'b0, a_c} + {1'b0, b_c};
   end

   // fitting only when the pair overruns; otherwise divide a by one
   always_comb begin
      pa    = a1_ff * s1_ff;
      pb    = b1_ff * s1_ff;
      dvd_a = fit1_ff ? pa : (2*QB)'(a1_ff);
      dvd_b = fit1_ff ? pb : (2*QB)'(b1_ff);
      dvs   = fit1_ff ? sum1_ff : (QB+1)'(1);
   end

   // restoring step; the quotient is below 2^QB so QB steps suffice
   always_comb begin
      for (int k = 0; k < QB; k++) begin
         t_a[k]  = {rem_a_ff[k], sh_a_ff[k][QB-1]};
         t_b[k]  = {rem_b_ff[k], sh_b_ff[k][QB-1]};
         df_a[k] = t_a[k] - {1'b0, d_ff[k]};
         df_b[k] = t_b[k] - {1'b0, d_ff[k]};
         ge_a[k] = t_a[k] >= {1'b0, d_ff[k]};
         ge_b[k] = t_b[k] >= {1'b0, d_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff       <= a_c;
         b1_ff       <= b_c;
         s1_ff       <= s_c;
         sum1_ff     <= sum_c;
         fit1_ff     <= sum_c > {1'b0, s_c};
         rem_a_ff[0] <= {1'b0, dvd_a[2*QB-1:QB]};
         rem_b_ff[0] <= {1'b0, dvd_b[2*QB-1:QB]};
         sh_a_ff[0]  <= dvd_a[QB-1:0];
         sh_b_ff[0]  <= dvd_b[QB-1:0];
         d_ff[0]     <= dvs;
         for (int k = 0; k < QB; k++) begin
            rem_a_ff[k+1] <= ge_a[k] ? df_a[k][QB:0] : t_a[k][QB:0];
            rem_b_ff[k+1] <= ge_b[k] ? df_b[k][QB:0] : t_b[k][QB:0];
            sh_a_ff[k+1]  <= {sh_a_ff[k][QB-2:0], ge_a[k]};
            sh_b_ff[k+1]  <= {sh_b_ff[k][QB-2:0], ge_b[k]};
            d_ff[k+1]     <= d_ff[k];
         end
      end
   end

   assign qa_out = sh_a_ff[QB];
   assign qb_out = sh_b_ff[QB];

endmodule

// ----- design/nsr_front.sv -----
// Front end: accepts rectangles, fits margins, builds cell edges and the emit mask.
module nsr_front import nsr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            cfg_wr,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            q_push,
   output queue_entry_type q_wdata,
   input  logic            q_full,
   output src_geom_type    geom
);

   localparam int L = LANE_STAGES;

   logic dirty_ff, dirty_in;
   logic busy_ff, busy_in;
   logic adv, accept, inject, cap, in_vld;
   item_kind_type in_kind;

   logic          vld_ff  [1:L];
   item_kind_type kind_ff [1:L];
   logic signed [COORD_BITS-1:0] x_ff [1:L];
   logic signed [COORD_BITS-1:0] y_ff [1:L];
   logic signed [COORD_BITS-1:0] w_ff [1:L];
   logic signed [COORD_BITS-1:0] h_ff [1:L];

   logic signed [COORD_BITS-1:0] l0_a, l0_b, l0_size, l1_a, l1_b, l1_size;
   logic [QB-1:0] q0a, q0b, q1a, q1b;

   logic signed [EB-1:0] xe, ye, we, he;
   logic signed [EB-1:0] dx_in [4];
   logic signed [EB-1:0] dy_in [4];
   logic                 e_vld_ff;
   logic signed [EB-1:0] e_dx_ff [4];
   logic signed [EB-1:0] e_dy_ff [4];

   src_geom_type          geom_ff;
   logic [2:0]            col_ok, row_ok;
   logic [CELL_COUNT-1:0] mask;

   // whole pipe holds only when the edge stage has something to queue and no room
   always_comb begin
      adv       = !(e_vld_ff && (mask != '0) && q_full);
      q_push    = e_vld_ff && (mask != '0) && !q_full;
      req_stall = dirty_ff | busy_ff | !adv;
      accept    = req_valid & !req_stall;
      inject    = dirty_ff & !busy_ff & adv;
      in_vld    = accept | inject;
      in_kind   = inject ? KIND_SRC_FIT : KIND_RECT;
      cap       = adv & vld_ff[L] & (kind_ff[L] == KIND_SRC_FIT);
      dirty_in  = cfg_wr | (dirty_ff & !inject);
      busy_in   = inject | (busy_ff & !cap);
   end

   // a refit borrows the same two lanes with the texture-side operands
   always_comb begin
      if (in_kind == KIND_SRC_FIT) begin
         l0_a    = cfg.source_left;
         l0_b    = cfg.source_right;
         l0_size = COORD_BITS'(cfg.tex_width);
         l1_a    = cfg.source_top;
         l1_b    = cfg.source_bottom;
         l1_size = COORD_BITS'(cfg.tex_height);
      end else begin
         l0_a    = req_data.target_left;
         l0_b    = req_data.target_right;
         l0_size = req_data.rect_width;
         l1_a    = req_data.target_top;
         l1_b    = req_data.target_bottom;
         l1_size = req_data.rect_height;
      end
   end

   nsr_fit_lane u_lane_x (
      .clock   (clock),
      .adv     (adv),
      .a_in    (l0_a),
      .b_in    (l0_b),
      .size_in (l0_size),
      .qa_out  (q0a),
      .qb_out  (q0b)
   );

   nsr_fit_lane u_lane_y (
      .clock   (clock),
      .adv     (adv),
      .a_in    (l1_a),
      .b_in    (l1_b),
      .size_in (l1_size),
      .qa_out  (q1a),
      .qb_out  (q1b)
   );

   always_comb begin
      xe       = EB'(x_ff[L]);
      ye       = EB'(y_ff[L]);
      we       = EB'(w_ff[L]);
      he       = EB'(h_ff[L]);
      dx_in[0] = xe;
      dx_in[1] = xe + EB'(q0a);
      dx_in[2] = xe + we - EB'(q0b);
      dx_in[3] = xe + we;
      dy_in[0] = ye;
      dy_in[1] = ye + EB'(q1a);
      dy_in[2] = ye + he - EB'(q1b);
      dy_in[3] = ye + he;
   end

   // a cell is drawn when both its texture and screen extents are positive
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_ok[c] = (geom_ff.sx[c+1] > geom_ff.sx[c]) && (e_dx_ff[c+1] > e_dx_ff[c]);
         row_ok[c] = (geom_ff.sy[c+1] > geom_ff.sy[c]) && (e_dy_ff[c+1] > e_dy_ff[c]);
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = row_ok[r] & col_ok[c];
         end
      end
      if (!cfg.center_enable) begin
         mask[CENTER_CELL] = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_wdata.dx[i] = e_dx_ff[i];
         q_wdata.dy[i] = e_dy_ff[i];
      end
      q_wdata.mask = mask;
   end

   assign geom = geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
         busy_ff  <= 1'b0;
         e_vld_ff <= 1'b0;
         geom_ff  <= '0;
         for (int k = 1; k <= L; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         dirty_ff <= dirty_in;
         busy_ff  <= busy_in;
         if (adv) begin
            vld_ff[1] <= in_vld;
            for (int k = 2; k <= L; k++) begin
               vld_ff[k] <= vld_ff[k-1];
            end
            e_vld_ff <= vld_ff[L] && (kind_ff[L] == KIND_RECT);
         end
         if (cap) begin
            geom_ff.sx[0] <= '0;
            geom_ff.sx[1] <= q0a;
            geom_ff.sx[2] <= cfg.tex_width - q0b;
            geom_ff.sx[3] <= cfg.tex_width;
            geom_ff.sy[0] <= '0;
            geom_ff.sy[1] <= q1a;
            geom_ff.sy[2] <= cfg.tex_height - q1b;
            geom_ff.sy[3] <= cfg.tex_height;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff[1] <= in_kind;
         x_ff[1]    <= req_data.rect_x;
         y_ff[1]    <= req_data.rect_y;
         w_ff[1]    <= req_data.rect_width;
         h_ff[1]    <= req_data.rect_height;
         for (int k = 2; k <= L; k++) begin
            kind_ff[k] <= kind_ff[k-1];
            x_ff[k]    <= x_ff[k-1];
            y_ff[k]    <= y_ff[k-1];
            w_ff[k]    <= w_ff[k-1];
            h_ff[k]    <= h_ff[k-1];
         end
         for (int i = 0; i < 4; i++) begin
            e_dx_ff[i] <= dx_in[i];
            e_dy_ff[i] <= dy_in[i];
         end
      end
   end

endmodule

// ----- design/nsr_fifo.sv -----
// Short queue of classified rectangles between front and back.
module nsr_fifo import nsr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type wdata,
   input  logic            pop,
   output queue_entry_type rdata,
   output logic            full,
   output logic            empty
);

   queue_entry_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS:0]   rd_ptr_ff, rd_ptr_in;

   always_comb begin
      empty     = wr_ptr_ff == rd_ptr_ff;
      full      = (wr_ptr_ff[QUEUE_PTR_BITS] != rd_ptr_ff[QUEUE_PTR_BITS]) &&
                  (wr_ptr_ff[QUEUE_PTR_BITS-1:0] == rd_ptr_ff[QUEUE_PTR_BITS-1:0]);
      rdata     = mem_ff[rd_ptr_ff[QUEUE_PTR_BITS-1:0]];
      wr_ptr_in = wr_ptr_ff + (QUEUE_PTR_BITS+1)'(push);
      rd_ptr_in = rd_ptr_ff + (QUEUE_PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[QUEUE_PTR_BITS-1:0]] <= wdata;
      end
   end

endmodule

// ----- design/nsr_back.sv -----
// Back end: walks a rectangle's emit mask, one cell pair per unstalled cycle.
module nsr_back import nsr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  queue_entry_type q_rdata,
   output logic            q_pop,
   input  src_geom_type    geom,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   logic [CELL_COUNT-1:0] cur_mask_ff, cur_mask_in;
   logic [3:0][EB-1:0]    cur_dx_ff, cur_dy_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free, emit, last;
   logic [CELL_COUNT-1:0] low, rest;
   logic [3:0]            idx;
   logic [1:0]            row, col;
   logic signed [EB-1:0]  dxc, dxn, dyc, dyn, dw, dh;

   always_comb begin
      out_free = !rsp_valid_ff | !rsp_stall;
      emit     = (cur_mask_ff != '0) & out_free;
      low      = cur_mask_ff & (~cur_mask_ff + CELL_COUNT'(1));
      rest     = cur_mask_ff & ~low;
      last     = rest == '0;
      q_pop    = !q_empty & ((cur_mask_ff == '0) | (emit & last));
      if (q_pop) begin
         cur_mask_in = q_rdata.mask;
      end else if (emit) begin
         cur_mask_in = rest;
      end else begin
         cur_mask_in = cur_mask_ff;
      end
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
   end

   always_comb begin
      idx = '0;
      for (int i = 0; i < CELL_COUNT; i++) begin
         if (low[i]) begin
            idx = 4'(i);
         end
      end
      row = cell_row(idx);
      col = cell_col(idx);
      dxc = $signed(cur_dx_ff[col]);
      dxn = $signed(cur_dx_ff[col + 2'd1]);
      dyc = $signed(cur_dy_ff[row]);
      dyn = $signed(cur_dy_ff[row + 2'd1]);
      dw  = dxn - dxc;
      dh  = dyn - dyc;

      rsp_data_in.cell_index       = idx;
      rsp_data_in.piece_src_x      = geom.sx[col];
      rsp_data_in.piece_src_y      = geom.sy[row];
      rsp_data_in.piece_src_width  = geom.sx[col + 2'd1] - geom.sx[col];
      rsp_data_in.piece_src_height = geom.sy[row + 2'd1] - geom.sy[row];
      rsp_data_in.piece_dst_x      = sat_coord(dxc);
      rsp_data_in.piece_dst_y      = sat_coord(dyc);
      rsp_data_in.piece_dst_width  = dw[QB-1:0];
      rsp_data_in.piece_dst_height = dh[QB-1:0];
      rsp_data_in.last_piece       = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_mask_ff  <= cur_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_dx_ff <= q_rdata.dx;
         cur_dy_ff <= q_rdata.dy;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/sv/nine_slice_rect_generator_checker.sv -----
`timescale 1ns / 1ps
// Checker for the nine-slice generator: follows register writes, predicts cells, compares.
module nine_slice_rect_generator_checker import nsr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       failures,
   output int                       pending
);

   // shadow of the register file
   logic [QB-1:0]                tex_w;
   logic [QB-1:0]                tex_h;
   logic signed [COORD_BITS-1:0] src_l;
   logic signed [COORD_BITS-1:0] src_t;
   logic signed [COORD_BITS-1:0] src_r;
   logic signed [COORD_BITS-1:0] src_b;
   logic                         center_on;

   rsp_type cell_expect_q[$];
   rsp_type want;
   int      mismatch_total;

   // margin m after clamping the pair (m, other) and fitting it into span
   function automatic longint fitted(input longint m, input longint other, input longint span);
      longint sum;
      if (m < 0) m = 0;
      if (other < 0) other = 0;
      if (span < 0) span = 0;
      sum = m + other;
      if (sum > span && sum > 0) m = (m * span) / sum;
      return m;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
      longint hi;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return COORD_BITS'(v);
   endfunction

   function automatic void predict_cells(input req_type r);
      longint  tw, th, sl, st, sr, sb, x, y, w, h, tl, tt, tr, tbm;
      longint  sx[4], sy[4], dx[4], dy[4];
      longint  sw, sh, dw, dh;
      rsp_type cells[9];
      int      n;
      tw  = longint'(tex_w);
      th  = longint'(tex_h);
      sl  = fitted(longint'(src_l), longint'(src_r), tw);
      sr  = fitted(longint'(src_r), longint'(src_l), tw);
      st  = fitted(longint'(src_t), longint'(src_b), th);
      sb  = fitted(longint'(src_b), longint'(src_t), th);
      x   = longint'($signed(r.rect_x));
      y   = longint'($signed(r.rect_y));
      w   = longint'($signed(r.rect_width));
      h   = longint'($signed(r.rect_height));
      tl  = fitted(longint'($signed(r.target_left)), longint'($signed(r.target_right)), w);
      tr  = fitted(longint'($signed(r.target_right)), longint'($signed(r.target_left)), w);
      tt  = fitted(longint'($signed(r.target_top)), longint'($signed(r.target_bottom)), h);
      tbm = fitted(longint'($signed(r.target_bottom)), longint'($signed(r.target_top)), h);
      sx = '{0, sl, tw - sr, tw};
      sy = '{0, st, th - sb, th};
      dx = '{x, x + tl, x + w - tr, x + w};
      dy = '{y, y + tt, y + h - tbm, y + h};
      n = 0;
      for (int row = 0; row < 3; row++) begin
         for (int col = 0; col < 3; col++) begin
            sw = sx[col + 1] - sx[col];
            sh = sy[row + 1] - sy[row];
            dw = dx[col + 1] - dx[col];
            dh = dy[row + 1] - dy[row];
            if (row * 3 + col == CENTER_CELL && !center_on) continue;
            if (sw <= 0 || sh <= 0 || dw <= 0 || dh <= 0) continue;
            cells[n]                  = '0;
            cells[n].cell_index       = 4'(row * 3 + col);
            cells[n].piece_src_x      = QB'(sx[col]);
            cells[n].piece_src_y      = QB'(sy[row]);
            cells[n].piece_src_width  = QB'(sw);
            cells[n].piece_src_height = QB'(sh);
            cells[n].piece_dst_x      = clamp_coord(dx[col]);
            cells[n].piece_dst_y      = clamp_coord(dy[row]);
            cells[n].piece_dst_width  = QB'(dw);
            cells[n].piece_dst_height = QB'(dh);
            n++;
         end
      end
      if (n > 0) cells[n - 1].last_piece = 1'b1;
      for (int i = 0; i < n; i++) cell_expect_q.push_back(cells[i]);
   endfunction

   function automatic int field_check(input string name, input longint exp_v, input longint got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tex_w     = '0;
         tex_h     = '0;
         src_l     = '0;
         src_t     = '0;
         src_r     = '0;
         src_b     = '0;
         center_on = 1'b1;
         cell_expect_q.delete();
         mismatch_total = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_BITS-1:2])
               CSR_TEX_WIDTH:     tex_w = csr_pwdata[QB-1:0];
               CSR_TEX_HEIGHT:    tex_h = csr_pwdata[QB-1:0];
               CSR_SOURCE_LEFT:   src_l = csr_pwdata[COORD_BITS-1:0];
               CSR_SOURCE_TOP:    src_t = csr_pwdata[COORD_BITS-1:0];
               CSR_SOURCE_RIGHT:  src_r = csr_pwdata[COORD_BITS-1:0];
               CSR_SOURCE_BOTTOM: src_b = csr_pwdata[COORD_BITS-1:0];
               CSR_CENTER_ENABLE: center_on = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (cell_expect_q.size() == 0) begin
               $display("%0t: unexpected cell, expected none, got %h", $time, rsp_data);
               mismatch_total++;
            end else begin
               want = cell_expect_q.pop_front();
               mismatch_total +=
                  field_check("cell_index", want.cell_index, rsp_data.cell_index) +
                  field_check("piece_src_x", want.piece_src_x, rsp_data.piece_src_x) +
                  field_check("piece_src_y", want.piece_src_y, rsp_data.piece_src_y) +
                  field_check("piece_src_width", want.piece_src_width,
                              rsp_data.piece_src_width) +
                  field_check("piece_src_height", want.piece_src_height,
                              rsp_data.piece_src_height) +
                  field_check("piece_dst_x", $signed(want.piece_dst_x),
                              $signed(rsp_data.piece_dst_x)) +
                  field_check("piece_dst_y", $signed(want.piece_dst_y),
                              $signed(rsp_data.piece_dst_y)) +
                  field_check("piece_dst_width", want.piece_dst_width,
                              rsp_data.piece_dst_width) +
                  field_check("piece_dst_height", want.piece_dst_height,
                              rsp_data.piece_dst_height) +
                  field_check("last_piece", want.last_piece, rsp_data.last_piece);
            end
         end
         if (req_valid && !req_stall) predict_cells(req_data);
      end
      failures <= mismatch_total;
      pending  <= cell_expect_q.size();
   end

endmodule

// ----- tb/sv/nine_slice_rect_generator_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the nine-slice generator: clock, reset, requests, register writes, verdict.
module nine_slice_rect_generator_tb;
   import nsr_pkg::*;

   localparam int PX             = 256;        // one pixel with 8 fraction bits
   localparam int COORD_MAX      = 8388607;
   localparam int COORD_MIN      = -8388608;
   localparam int SIZE_MAX       = 8388607;    // largest 23-bit size
   localparam int DRAIN_CYCLES   = 64;         // covers the pipe plus the re-fit
   localparam int HOLDOFF_CYCLES = 400;        // long receiver hold-off, fills queue and pipe
   localparam int RANDOM_PHASES  = 7;
   localparam int REQS_PER_PHASE = 50;
   localparam int CYCLE_LIMIT    = 200000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int check_failures;
   int cells_pending;
   int req_idle_pct;       // chance in percent that the sender skips a cycle
   int rsp_idle_pct;       // chance in percent that the receiver stalls a cycle
   int holdoff_requests;   // bumped by the stimulus, served by the receiver
   int cycle_count;

   nine_slice_rect_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The checker sees exactly what the block sees, at the same edges.
   nine_slice_rect_generator_checker cell_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .failures    (check_failures),
      .pending     (cells_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Receiver side. A requested hold-off keeps rsp_stall high for a long stretch
   // regardless of the random idling, so the 4-entry queue and the fitting pipe
   // back up and req_stall has to rise.
   initial begin
      int holdoff_left;
      int holdoffs_done;
      holdoff_left  = 0;
      holdoffs_done = 0;
      rsp_stall     = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoffs_done != holdoff_requests) begin
            holdoffs_done++;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   function automatic req_type rect_of(input int x, input int y, input int w, input int h,
                                       input int l, input int t, input int r, input int b);
      req_type q;
      q.rect_x        = COORD_BITS'(x);
      q.rect_y        = COORD_BITS'(y);
      q.rect_width    = COORD_BITS'(w);
      q.rect_height   = COORD_BITS'(h);
      q.target_left   = COORD_BITS'(l);
      q.target_top    = COORD_BITS'(t);
      q.target_right  = COORD_BITS'(r);
      q.target_bottom = COORD_BITS'(b);
      return q;
   endfunction

   // Offer one request, with random idle cycles in front; returns at the accepting edge.
   // valid stays high on return so back-to-back requests need no second assignment.
   task automatic send_rect(input req_type r);
      while (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, wait for every predicted cell, then cover requests that draw nothing
   // and are still in the pipe.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cells_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then one cycle with psel low.
   task automatic csr_write(input int idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input int tw, input int th, input int sl, input int st,
                                 input int sr, input int sb, input int dc);
      csr_write(CSR_TEX_WIDTH, tw);
      csr_write(CSR_TEX_HEIGHT, th);
      csr_write(CSR_SOURCE_LEFT, sl);
      csr_write(CSR_SOURCE_TOP, st);
      csr_write(CSR_SOURCE_RIGHT, sr);
      csr_write(CSR_SOURCE_BOTTOM, sb);
      csr_write(CSR_CENTER_ENABLE, dc);
   endtask

   // Source margin: mostly inside the texture, sometimes negative or oversized.
   function automatic int pick_source_margin(input int span);
      int m;
      case ($urandom_range(0, 5))
         0:       m = -int'($urandom_range(1, 8388608));
         1: begin
            m = int'($urandom_range(0, 2 * span));
            if (m > COORD_MAX) m = COORD_MAX;
         end
         default: m = int'($urandom_range(0, span / 2));
      endcase
      return m;
   endfunction

   initial begin
      int     tw, th, dc;
      int     x, y, w, h, ml, mt, mr, mb;
      req_type r;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_idle_pct     = 33;
      rsp_idle_pct     = 51;
      holdoff_requests = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: 64x48 px texture with uneven source margins.
      wait_idle();
      write_settings(64 * PX, 48 * PX, 8 * PX, 4 * PX, 12 * PX, 6 * PX, 1);
      // index past the register list must not land anywhere
      csr_write(CSR_COUNT, -1);

      // full grid, all nine cells
      send_rect(rect_of(10 * PX, 20 * PX, 100 * PX, 80 * PX, 10 * PX, 10 * PX, 10 * PX, 10 * PX));
      // zero margins: only the center has destination area
      send_rect(rect_of(0, 0, 50 * PX, 40 * PX, 0, 0, 0, 0));
      // negative margins clamp to zero
      send_rect(rect_of(-5 * PX, -7 * PX, 30 * PX, 30 * PX, -1, -PX, COORD_MIN, -100));
      // margin pairs larger than the rectangle get scaled down
      send_rect(rect_of(0, 0, 20 * PX, 10 * PX, 30 * PX, 30 * PX, 30 * PX, 10 * PX));
      // one margin alone larger than the size
      send_rect(rect_of(PX, PX, 20 * PX, 20 * PX, 40 * PX, 0, 0, 5 * PX));
      // margins sum exactly to the size: middle row and column vanish
      send_rect(rect_of(0, 0, 20 * PX, 20 * PX, 10 * PX, 5 * PX, 10 * PX, 15 * PX));
      // negative or zero size: nothing drawn
      send_rect(rect_of(0, 0, -10 * PX, 20 * PX, PX, PX, PX, PX));
      send_rect(rect_of(0, 0, 20 * PX, -10 * PX, PX, PX, PX, PX));
      send_rect(rect_of(3 * PX, 4 * PX, 0, 0, 0, 0, 0, 0));
      // smallest positive size
      send_rect(rect_of(0, 0, 1, 1, 0, 0, 0, 0));
      // destination edges run past the top of the range and saturate; then edges at the bottom end
      send_rect(rect_of(COORD_MAX - 10 * PX, COORD_MAX - 5 * PX, 100 * PX, 30 * PX,
                        10 * PX, 10 * PX, 10 * PX, 10 * PX));
      send_rect(rect_of(COORD_MIN, COORD_MIN, 30 * PX, 30 * PX, 5 * PX, 5 * PX, 5 * PX, 5 * PX));
      // field extremes
      send_rect(rect_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_rect(rect_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_rect(rect_of(-1, -1, -1, -1, -1, -1, -1, -1));
      send_rect(rect_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
      send_rect(rect_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
      // alternating bit patterns
      send_rect(rect_of('hAAAAAA, 'hAAAAAA, 'hAAAAAA, 'hAAAAAA,
                        'hAAAAAA, 'hAAAAAA, 'hAAAAAA, 'hAAAAAA));
      send_rect(rect_of('h555555, 'h555555, 'h555555, 'h555555,
                        'h555555, 'h555555, 'h555555, 'h555555));
      send_rect(rect_of('h555555, -'h2AAAAA, 'h2AAAAA, 'h155555,
                        'h0AAAAA, 'h055555, 'h0AAAAA, 'h055555));

      // Random part. Each phase drains, reprograms, then streams requests.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         // idling: sender light / receiver heavy, then swapped, then none at all
         if (phase == 3) begin
            req_idle_pct = 51;
            rsp_idle_pct = 33;
         end else if (phase == 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (phase)
            1: begin
               // largest texture, source margins at their maximum, center off
               write_settings(SIZE_MAX, SIZE_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
            end
            2: begin
               // empty texture: every request draws nothing
               write_settings(0, 0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1);
            end
            default: begin
               tw = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, SIZE_MAX))
                                                : int'($urandom_range(1, 256)) * PX;
               th = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, SIZE_MAX))
                                                : int'($urandom_range(1, 256)) * PX;
               dc = (phase == 3) ? 0 : int'($urandom_range(0, 1));
               write_settings(tw, th, pick_source_margin(tw), pick_source_margin(th),
                              pick_source_margin(tw), pick_source_margin(th), dc);
            end
         endcase

         // long receiver hold-off while the sender keeps offering
         if (phase == 0) holdoff_requests++;

         repeat (REQS_PER_PHASE) begin
            // typical well-formed rectangle with margins inside it
            x  = int'($urandom_range(0, 2097152)) - 1048576;
            y  = int'($urandom_range(0, 2097152)) - 1048576;
            w  = int'($urandom_range(1, 65536));
            h  = int'($urandom_range(1, 65536));
            ml = int'($urandom_range(0, w / 3));
            mr = int'($urandom_range(0, w / 3));
            mt = int'($urandom_range(0, h / 3));
            mb = int'($urandom_range(0, h / 3));
            case ($urandom_range(0, 9))
               0: begin
                  // raw bits everywhere
                  x  = $urandom;
                  y  = $urandom;
                  w  = $urandom;
                  h  = $urandom;
                  ml = $urandom;
                  mt = $urandom;
                  mr = $urandom;
                  mb = $urandom;
               end
               1: begin
                  // near the ends of the coordinate range
                  x = $urandom_range(0, 1) ? COORD_MAX - int'($urandom_range(0, w))
                                           : COORD_MIN + int'($urandom_range(0, w));
                  y = $urandom_range(0, 1) ? COORD_MAX - int'($urandom_range(0, h))
                                           : COORD_MIN + int'($urandom_range(0, h));
               end
               2: begin
                  // oversized margins force scaling
                  ml = int'($urandom_range(0, 2 * w));
                  mr = int'($urandom_range(0, 2 * w));
                  mt = int'($urandom_range(0, 2 * h));
                  mb = int'($urandom_range(0, 2 * h));
               end
               3: begin
                  // negative sizes and margins
                  if ($urandom_range(0, 1)) w = -int'($urandom_range(0, 65536));
                  if ($urandom_range(0, 1)) h = -int'($urandom_range(0, 65536));
                  ml = -int'($urandom_range(1, 4096));
                  mb = -int'($urandom_range(1, 4096));
               end
               default: ;
            endcase
            send_rect(rect_of(x, y, w, h, ml, mt, mr, mb));
         end
      end

      wait_idle();
      if (check_failures == 0 && cells_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
